FILE: design/psac_pkg.sv
package psac_pkg;

    // Stream payload widths (whole bytes)
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Counter layout: V H YYYYY XXXXX
    localparam logic [11:0] COARSE_Y_MASK  = 12'h3E0;
    localparam logic [11:0] COARSE_Y_AT_29 = 12'h3A0;
    localparam logic [11:0] V_BIT          = 12'h800;
    localparam logic [11:0] H_BIT          = 12'h400;
    localparam logic [11:0] HORIZ_MASK     = 12'h41F;
    localparam logic [11:0] VERT_MASK      = 12'hBE0;

    typedef enum logic [3:0] {
        OP_CTRL    = 4'd0,
        OP_SCROLL1 = 4'd1,
        OP_SCROLL2 = 4'd2,
        OP_ADDR1   = 4'd3,
        OP_ADDR2   = 4'd4,
        OP_COPYH   = 4'd5,
        OP_COPYV   = 4'd6,
        OP_INCV    = 4'd7,
        OP_INCH    = 4'd8,
        OP_ADD1    = 4'd9,
        OP_ADD32   = 4'd10
    } psac_op_t;

    typedef struct packed {
        logic [11:0] latched_counters;
        logic [2:0]  latched_fine_y;
        logic [11:0] live_counters;
        logic [2:0]  fine_x;
        logic [2:0]  fine_y;
        logic        pattern_bit;
    } psac_state_t;

endpackage

FILE: design/psac_update.sv
// Next-state logic for one event.
module psac_update (
    input  logic [3:0]           operation,
    input  logic [7:0]           value,
    input  psac_pkg::psac_state_t state_cur,
    output psac_pkg::psac_state_t state_nxt
);

    logic [14:0] full_addr;
    logic [11:0] latch_addr2;

    assign full_addr   = {state_cur.fine_y, state_cur.live_counters};
    assign latch_addr2 = {state_cur.latched_counters[11:8], value};

    always_comb begin
        state_nxt = state_cur;
        case (operation)
            psac_pkg::OP_CTRL: begin
                state_nxt.latched_counters[11:10] = value[1:0];
                state_nxt.pattern_bit             = value[4];
            end
            psac_pkg::OP_SCROLL1: begin
                state_nxt.fine_x                 = value[2:0];
                state_nxt.latched_counters[4:0]  = value[7:3];
            end
            psac_pkg::OP_SCROLL2: begin
                state_nxt.latched_fine_y         = value[2:0];
                state_nxt.latched_counters[9:5]  = value[7:3];
            end
            psac_pkg::OP_ADDR1: begin
                state_nxt.latched_counters[11:8] = value[3:0];
                state_nxt.latched_fine_y         = {1'b0, value[5:4]};
            end
            psac_pkg::OP_ADDR2: begin
                state_nxt.latched_counters = latch_addr2;
                state_nxt.live_counters    = latch_addr2;
                state_nxt.fine_y           = state_cur.latched_fine_y;
            end
            psac_pkg::OP_COPYH: begin
                state_nxt.live_counters =
                    (state_cur.live_counters & psac_pkg::VERT_MASK) |
                    (state_cur.latched_counters & psac_pkg::HORIZ_MASK);
            end
            psac_pkg::OP_COPYV: begin
                state_nxt.live_counters =
                    (state_cur.live_counters & psac_pkg::HORIZ_MASK) |
                    (state_cur.latched_counters & psac_pkg::VERT_MASK);
                state_nxt.fine_y = state_cur.latched_fine_y;
            end
            psac_pkg::OP_INCV: begin
                if (state_cur.fine_y != 3'd7) begin
                    state_nxt.fine_y = state_cur.fine_y + 3'd1;
                end else begin
                    state_nxt.fine_y = 3'd0;
                    if ((state_cur.live_counters & psac_pkg::COARSE_Y_MASK) ==
                        psac_pkg::COARSE_Y_AT_29) begin
                        state_nxt.live_counters =
                            (state_cur.live_counters & ~psac_pkg::COARSE_Y_MASK) ^
                            psac_pkg::V_BIT;
                    end else if ((state_cur.live_counters & psac_pkg::COARSE_Y_MASK) ==
                                 psac_pkg::COARSE_Y_MASK) begin
                        // row 31: wrap, nametable stays
                        state_nxt.live_counters =
                            state_cur.live_counters & ~psac_pkg::COARSE_Y_MASK;
                    end else begin
                        state_nxt.live_counters = state_cur.live_counters + 12'd32;
                    end
                end
            end
            psac_pkg::OP_INCH: begin
                if (state_cur.live_counters[4:0] == 5'h1F) begin
                    state_nxt.live_counters =
                        {state_cur.live_counters[11:5], 5'd0} ^ psac_pkg::H_BIT;
                end else begin
                    state_nxt.live_counters = state_cur.live_counters + 12'd1;
                end
            end
            psac_pkg::OP_ADD1: begin
                {state_nxt.fine_y, state_nxt.live_counters} = full_addr + 15'd1;
            end
            psac_pkg::OP_ADD32: begin
                {state_nxt.fine_y, state_nxt.live_counters} = full_addr + 15'd32;
            end
            default: begin
                // unused codes: no change
            end
        endcase
    end

endmodule

FILE: design/ppu_scroll_address_counters_core.sv
// Scroll and address counters of a tile video unit (V H coarse-Y coarse-X
// layout). Each input transfer carries one event (register write or counter
// action); each event yields exactly one output transfer with the state
// after it. One event per cycle is accepted, back to back: a registered input
// stage feeds the next-state logic, whose result is captured together with
// the live state in the output register. An event passes through the input
// register and then the output register before output valid; throughput is
// one event per cycle as long as m_tready stays high, and back-pressure
// stalls the input stage only when both stages are full.
module ppu_scroll_address_counters_core (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [3:0] operation, [11:4] value, [15:12] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [psac_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: [14:0] vram_address, [17:15] fine_x_scroll,
    //          [18] pattern_select, [23:19] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [psac_pkg::M_TDATA_W-1:0] m_tdata
);

    // input stage
    logic       in_valid_reg;
    logic [3:0] in_op_reg;
    logic [7:0] in_value_reg;

    // architectural state
    psac_pkg::psac_state_t state_reg;
    psac_pkg::psac_state_t state_next;

    // output stage
    logic        out_valid_reg;
    logic [14:0] out_addr_reg;
    logic [2:0]  out_fine_x_reg;
    logic        out_pattern_reg;

    logic advance;
    logic s_xfer;

    // move the held event into the state when the output slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_op_reg    <= s_tdata[3:0];
            in_value_reg <= s_tdata[11:4];
        end
    end

    psac_update u_update (
        .operation (in_op_reg),
        .value     (in_value_reg),
        .state_cur (state_reg),
        .state_nxt (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload: the state right after the event
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_addr_reg    <= {state_next.fine_y, state_next.live_counters};
            out_fine_x_reg  <= state_next.fine_x;
            out_pattern_reg <= state_next.pattern_bit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_pattern_reg, out_fine_x_reg, out_addr_reg};

endmodule

FILE: design/psac_checker.sv
// Port-level checks for the scroll counter core.
module psac_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [psac_pkg::S_TDATA_W-1:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [psac_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // reset empties the output stage
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // empty output stage never back-pressures the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // an event accepted while the output stage is empty shows up at the output
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing after transfer");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:19] == 5'd0)
        else $error("padding bits set");

endmodule

bind ppu_scroll_address_counters_core psac_checker u_psac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
